/* rtl/beao_pkg.sv */
`timescale 1ns / 1ps
package beao_pkg;

	localparam int FRAC_BITS    = 20;
	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_KW    = $clog2(CORDIC_STEPS + 1);
	localparam int ANGLE_W      = 23;
	localparam int CX_W         = 35;
	localparam int CZ_W         = 34;
	localparam int ROUND_SH     = 30 - FRAC_BITS;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam logic signed [CZ_W-1:0] PI_FRAC =
		CZ_W'((PI_Q30 + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);

	localparam logic [1:0] REG_DECAY   = 2'd0;
	localparam logic [1:0] REG_DRIVE   = 2'd1;
	localparam logic [1:0] REG_CUR_COR = 2'd2;
	localparam logic [1:0] REG_EMF_COR = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_MA, ST_MB, ST_ML1, ST_ML2, ST_UPD, ST_CORD, ST_OUT
	} obs_state_t;

	typedef enum logic {
		CR_IDLE, CR_RUN
	} cordic_state_t;

	function automatic logic signed [CZ_W-1:0] atan_frac(input int k);
		longint q;
		case (k)
			0: q = 843314857;
			1: q = 497837829;
			2: q = 263043837;
			3: q = 133525159;
			4: q = 67021687;
			5: q = 33543516;
			6: q = 16775851;
			7: q = 8388437;
			8: q = 4194283;
			9: q = 2097149;
			10: q = 1048576;
			11: q = 524288;
			12: q = 262144;
			13: q = 131072;
			14: q = 65536;
			15: q = 32768;
			16: q = 16384;
			17: q = 8192;
			18: q = 4096;
			19: q = 2048;
			20: q = 1024;
			21: q = 512;
			22: q = 256;
			23: q = 128;
			24: q = 64;
			25: q = 32;
			26: q = 16;
			27: q = 8;
			28: q = 4;
			29: q = 2;
			30: q = 1;
			default: q = 0;
		endcase
		return CZ_W'((q + (64'sd1 <<< (ROUND_SH - 1))) >>> ROUND_SH);
	endfunction

endpackage

/* rtl/beao_cordic.sv */
`timescale 1ns / 1ps
module beao_cordic import beao_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        y_in,
	input  logic signed [31:0]        x_in,
	output logic                      done,
	output logic        [ANGLE_W-1:0] angle
);

	cordic_state_t state_q, state_d;
	logic [CORDIC_KW-1:0] k_q, k_d;
	logic signed [CX_W-1:0] x_q, y_q, dx, dy, xe, ye;
	logic signed [CZ_W-1:0] z_q, t, zs;
	logic done_q, done_d;
	logic zero_in;

	assign xe = CX_W'(x_in);
	assign ye = CX_W'(y_in);
	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign t  = atan_frac(int'(k_q));
	assign zero_in = (x_in == 32'sd0) && (y_in == 32'sd0);

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		done_d  = 1'b0;
		case (state_q)
			CR_IDLE: begin
				if (start) begin
					k_d = '0;
					if (zero_in) begin
						done_d = 1'b1;
					end else begin
						state_d = CR_RUN;
					end
				end
			end
			CR_RUN: begin
				k_d = k_q + CORDIC_KW'(1);
				if (k_q == CORDIC_KW'(CORDIC_STEPS - 1)) begin
					state_d = CR_IDLE;
					done_d  = 1'b1;
				end
			end
			default: state_d = CR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CR_IDLE && start) begin
			if (zero_in) begin
				z_q <= '0;
			end else if (x_in < 0) begin
				x_q <= -xe;
				y_q <= -ye;
				z_q <= (y_in >= 0) ? PI_FRAC : -PI_FRAC;
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (state_q == CR_RUN) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + t;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - t;
			end
		end
	end

	always_comb begin
		zs = z_q;
		if (z_q > PI_FRAC) zs = PI_FRAC;
		if (z_q < -PI_FRAC) zs = -PI_FRAC;
	end

	assign angle = zs[ANGLE_W-1:0];
	assign done  = done_q;

endmodule

/* rtl/back_emf_angle_observer.sv */
`timescale 1ns / 1ps
// Back-EMF angle observer.
// Input channel s_*: one request per control period with stator voltages
// and measured currents (tdata: volt_alpha, volt_beta, amps_alpha, amps_beta).
// Output channel m_*: rotor angle and updated back-EMF estimates.
// Gains are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// Each request runs six steps per axis on the one shared 32x32 multiplier,
// then one CORDIC iteration per cycle. When both estimates are zero the
// CORDIC iterations are skipped and the angle is zero. s_tready is high only
// while the sequencer is idle.
// A finished result sits in the output register; the next request may be
// taken meanwhile, and its result waits in the final step until the
// receiver takes the previous one. m_tvalid holds until m_tready.
// Reset clears the estimates to zero, loads the default gains and drops
// any pending result.
module back_emf_angle_observer import beao_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // volt_alpha, volt_beta, amps_alpha, amps_beta
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,  // rotor_angle[22:0], emf_alpha_out, emf_beta_out, pad
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	obs_state_t state_q, state_d;
	logic ax_q;
	logic signed [31:0] gain_decay_q, gain_drive_q, gain_cur_q, gain_emf_q;
	logic signed [31:0] volt_q [2];
	logic signed [31:0] amps_q [2];
	logic signed [31:0] cur_q [2];
	logic signed [31:0] emf_q [2];
	logic signed [31:0] err_q, diff_q, acc_q, p, mul_a, mul_b;
	logic signed [63:0] prod_q;
	logic out_valid_q;
	logic [ANGLE_W-1:0] angle_q, angle;
	logic [31:0] emf_a_out_q, emf_b_out_q;
	logic cordic_start, cordic_done;
	logic out_free;

	assign p = prod_q[FRAC_BITS+31:FRAC_BITS];
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		case (state_q)
			ST_MA:   begin mul_a = gain_decay_q; mul_b = cur_q[ax_q]; end
			ST_MB:   begin mul_a = gain_drive_q; mul_b = diff_q; end
			ST_ML1:  begin mul_a = gain_cur_q;   mul_b = err_q; end
			default: begin mul_a = gain_emf_q;   mul_b = err_q; end
		endcase
	end

	always_comb begin
		state_d      = state_q;
		cordic_start = 1'b0;
		case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_ERR;
			ST_ERR:  state_d = ST_MA;
			ST_MA:   state_d = ST_MB;
			ST_MB:   state_d = ST_ML1;
			ST_ML1:  state_d = ST_ML2;
			ST_ML2:  state_d = ST_UPD;
			ST_UPD:  state_d = ax_q ? ST_CORD : ST_ERR;
			ST_CORD: begin
				cordic_start = !ax_q;
				if (cordic_done) state_d = ST_OUT;
			end
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ax_q         <= 1'b0;
			out_valid_q  <= 1'b0;
			gain_decay_q <= -32'sd59919;
			gain_drive_q <= 32'sd299593;
			gain_cur_q   <= -32'sd922747;
			gain_emf_q   <= 32'sd3439329;
			cur_q[0]     <= '0;
			cur_q[1]     <= '0;
			emf_q[0]     <= '0;
			emf_q[1]     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_DECAY:   gain_decay_q <= cfg_data;
					REG_DRIVE:   gain_drive_q <= cfg_data;
					REG_CUR_COR: gain_cur_q   <= cfg_data;
					REG_EMF_COR: gain_emf_q   <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE) ax_q <= 1'b0;
			else if (state_q == ST_UPD) ax_q <= !ax_q;
			else if (state_q == ST_CORD) ax_q <= 1'b1;
			if (state_q == ST_UPD) begin
				cur_q[ax_q] <= acc_q;
				emf_q[ax_q] <= emf_q[ax_q] + p;
			end
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			volt_q[0] <= s_tdata[31:0];
			volt_q[1] <= s_tdata[63:32];
			amps_q[0] <= s_tdata[95:64];
			amps_q[1] <= s_tdata[127:96];
		end
		case (state_q)
			ST_ERR: begin
				err_q  <= cur_q[ax_q] - amps_q[ax_q];
				diff_q <= volt_q[ax_q] - emf_q[ax_q];
				acc_q  <= cur_q[ax_q];
			end
			ST_MA: prod_q <= mul_a * mul_b;
			ST_MB, ST_ML1, ST_ML2: begin
				acc_q  <= acc_q + p;
				prod_q <= mul_a * mul_b;
			end
			default: ;
		endcase
		if (state_q == ST_OUT && out_free) begin
			angle_q     <= angle;
			emf_a_out_q <= emf_q[0];
			emf_b_out_q <= emf_q[1];
		end
	end

	beao_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.y_in   (emf_q[1]),
		.x_in   (emf_q[0]),
		.done   (cordic_done),
		.angle  (angle)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, emf_b_out_q, emf_a_out_q, angle_q};

	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_start |=> !cordic_start)
		else $error("cordic started twice");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == ST_CORD)
		else $error("cordic done outside wait");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_free) |=> m_tvalid)
		else $error("result not presented");

endmodule
